/* src/first_fit_heap_allocator_defines.svh */
// Assertion macros shared by the checker of the first-fit heap allocator.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Implication checked at every rising edge outside reset.
`define FFHA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check with the clock and reset named by the house convention.
`define FFHA_CHECK(lbl, prop, msg) \
  `FFHA_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

/* src/ffha_pkg.sv */
// Shared constants, entry layout and control types of the heap allocator.
// Depends on nothing; used by the controller, the datapath and the top level.
`default_nettype none

package ffha_pkg;

  localparam int unsigned HeapMaxBytes = 4096;
  localparam int unsigned AlignBytes   = 8;
  localparam int unsigned HeaderBytes  = 16;
  localparam int unsigned GranBits     = $clog2(AlignBytes);
  localparam int unsigned Entries      = HeapMaxBytes / AlignBytes;
  localparam int unsigned IdxW         = $clog2(Entries);
  localparam int unsigned AddrW        = 13;
  localparam int unsigned SizeW        = 13;
  localparam int unsigned ReqW         = 16;
  localparam int unsigned PtrW         = 12;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_ZERO   = 3'd1,
    ST_NOMEM  = 3'd2,
    ST_BADPTR = 3'd3,
    ST_DFREE  = 3'd4
  } status_e;

  // One block descriptor, kept per granule.
  typedef struct packed {
    logic             used;   // a block header begins here
    logic             taken;  // the block is allocated
    logic [SizeW-1:0] size;   // payload bytes
  } entry_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_FIRST,
    OP_ADVANCE,
    OP_FMATCH,
    OP_SPLIT,
    OP_GRANT_FULL,
    OP_GRANT_AL,
    OP_NEXT_EVAL,
    OP_PREV_MERGE,
    OP_SELF_FREE,
    OP_SELF_CLEAR
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic zero;
    logic too_big;
    logic ptr_bad;
    logic used;
    logic taken;
    logic fits;
    logic match;
    logic adv_ok;
    logic split;
    logic prev_merge;
  } stat_t;

endpackage

`default_nettype wire

/* src/ffha_controller.sv */
// Sequencing state machine of the heap allocator.
// Depends on ffha_pkg; drives ffha_datapath through cmd_t and reads stat_t.
`default_nettype none

module ffha_controller (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic           start,
  output logic                busy,
  output ffha_pkg::cmd_t      cmd_o,
  input  wire ffha_pkg::stat_t stat_i,
  output logic                done_o,
  output logic [2:0]          status_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_WALK, S_GRANT, S_GRANT2, S_FNEXT, S_FPREV, S_FCLR
  } state_e;

  state_e            state_q, state_d;
  logic              done_q, fin;
  ffha_pkg::status_e status_q, fin_code;
  ffha_pkg::dp_op_e  op;

  always_comb begin
    state_d  = state_q;
    op       = ffha_pkg::OP_NONE;
    fin      = 1'b0;
    fin_code = ffha_pkg::ST_OK;
    case (state_q)
      S_CLEAR: begin
        op = ffha_pkg::OP_CLEAR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          op      = ffha_pkg::OP_LOAD;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat_i.is_free && stat_i.zero) begin
          fin      = 1'b1;
          fin_code = ffha_pkg::ST_ZERO;
        end else if (!stat_i.is_free && stat_i.too_big) begin
          fin      = 1'b1;
          fin_code = ffha_pkg::ST_NOMEM;
        end else if (stat_i.is_free && stat_i.ptr_bad) begin
          fin      = 1'b1;
          fin_code = ffha_pkg::ST_BADPTR;
        end else begin
          op      = ffha_pkg::OP_FIRST;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (!stat_i.used) begin
          fin      = 1'b1;
          fin_code = stat_i.is_free ? ffha_pkg::ST_OK : ffha_pkg::ST_NOMEM;
        end else if (!stat_i.is_free) begin
          if (stat_i.fits) begin
            state_d = S_GRANT;
          end else if (stat_i.adv_ok) begin
            op = ffha_pkg::OP_ADVANCE;
          end else begin
            fin      = 1'b1;
            fin_code = ffha_pkg::ST_NOMEM;
          end
        end else if (stat_i.match) begin
          if (stat_i.taken) begin
            op      = ffha_pkg::OP_FMATCH;
            state_d = S_FNEXT;
          end else begin
            fin      = 1'b1;
            fin_code = ffha_pkg::ST_DFREE;
          end
        end else if (stat_i.adv_ok) begin
          op = ffha_pkg::OP_ADVANCE;
        end else begin
          fin = 1'b1;
        end
      end
      S_GRANT: begin
        if (stat_i.split) begin
          op      = ffha_pkg::OP_SPLIT;
          state_d = S_GRANT2;
        end else begin
          op  = ffha_pkg::OP_GRANT_FULL;
          fin = 1'b1;
        end
      end
      S_GRANT2: begin
        op  = ffha_pkg::OP_GRANT_AL;
        fin = 1'b1;
      end
      S_FNEXT: begin
        op      = ffha_pkg::OP_NEXT_EVAL;
        state_d = S_FPREV;
      end
      S_FPREV: begin
        if (stat_i.prev_merge) begin
          op      = ffha_pkg::OP_PREV_MERGE;
          state_d = S_FCLR;
        end else begin
          op  = ffha_pkg::OP_SELF_FREE;
          fin = 1'b1;
        end
      end
      S_FCLR: begin
        op  = ffha_pkg::OP_SELF_CLEAR;
        fin = 1'b1;
      end
      default: state_d = S_CLEAR;
    endcase
    if (fin) state_d = S_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      done_q   <= 1'b0;
      status_q <= ffha_pkg::ST_OK;
    end else begin
      state_q <= cfg_we_i ? S_CLEAR : state_d;
      done_q  <= fin;
      if (fin) status_q <= fin_code;
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign cmd_o.op = op;
  assign done_o   = done_q;
  assign status_o = status_q;

endmodule

`default_nettype wire

/* src/ffha_datapath.sv */
// Datapath of the heap allocator: block table memory, walk pointers, sizes, free total.
// Depends on ffha_pkg; steered by ffha_controller through cmd_t.
`default_nettype none

module ffha_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ffha_pkg::SizeW-1:0]   cfg_wdata_i,
  input  wire logic                         kind_i,
  input  wire logic [ffha_pkg::ReqW-1:0]    request_bytes_i,
  input  wire logic [ffha_pkg::PtrW-1:0]    payload_offset_i,
  input  wire ffha_pkg::cmd_t               cmd_i,
  output ffha_pkg::stat_t                   stat_o,
  output logic [ffha_pkg::PtrW-1:0]         granted_o,
  output logic [ffha_pkg::SizeW-1:0]        free_o
);

  localparam int unsigned AW = ffha_pkg::AddrW;
  localparam int unsigned SW = ffha_pkg::SizeW;
  localparam int unsigned IW = ffha_pkg::IdxW;
  localparam int unsigned GB = ffha_pkg::GranBits;
  localparam logic [SW-1:0] Hdr  = SW'(ffha_pkg::HeaderBytes);
  localparam logic [SW-1:0] HMax = SW'(ffha_pkg::HeapMaxBytes);

  ffha_pkg::entry_t mem [ffha_pkg::Entries];
  ffha_pkg::entry_t rdata_q, blk_q, prev_ent_q, wd, e;

  logic [SW-1:0]              heap_q, free_q, al_q, news_q, len, room, lenw;
  logic [IW-1:0]              clr_q, wa, ra;
  logic                       kind_q, have_prev_q, nrd_q, we, re, tiny, nmerge;
  logic [ffha_pkg::ReqW-1:0]  req_q;
  logic [ffha_pkg::PtrW-1:0]  ptr_q, granted_q;
  logic [AW-1:0]              cur_q, prev_q;
  logic [AW:0]                nxt, split_n, blk_n;
  logic [ffha_pkg::ReqW:0]    al_raw;

  assign e      = rdata_q;
  assign len    = (heap_q > HMax) ? HMax : heap_q;
  assign lenw   = (cfg_wdata_i > HMax) ? HMax : cfg_wdata_i;
  assign tiny   = (len <= Hdr);
  assign room   = len - Hdr;
  assign nxt    = {1'b0, cur_q} + {1'b0, Hdr} + {1'b0, e.size};
  assign split_n = {1'b0, cur_q} + {1'b0, Hdr} + {1'b0, al_q};
  assign blk_n  = {1'b0, cur_q} + {1'b0, Hdr} + {1'b0, blk_q.size};
  assign nmerge = nrd_q && e.used && !e.taken;
  assign al_raw = ({1'b0, req_q} + (ffha_pkg::ReqW+1)'(ffha_pkg::AlignBytes - 1))
                  & ~(ffha_pkg::ReqW+1)'(ffha_pkg::AlignBytes - 1);

  always_comb begin
    stat_o.clr_last   = (clr_q == IW'(ffha_pkg::Entries - 1));
    stat_o.is_free    = kind_q;
    stat_o.zero       = (req_q == '0);
    stat_o.too_big    = tiny || (req_q > ffha_pkg::ReqW'(room));
    stat_o.ptr_bad    = (ptr_q == '0) || ({1'b0, ptr_q} >= len);
    stat_o.used       = e.used;
    stat_o.taken      = e.taken;
    stat_o.fits       = !e.taken && (e.size >= al_q);
    stat_o.match      = (({1'b0, cur_q} + {1'b0, Hdr}) == (AW+1)'(ptr_q));
    stat_o.adv_ok     = (nxt < {1'b0, len});
    stat_o.split      = ({1'b0, e.size} > ({1'b0, al_q} + {1'b0, Hdr}));
    stat_o.prev_merge = have_prev_q && !prev_ent_q.taken;
  end

  // Table port selection per controller step.
  always_comb begin
    we = 1'b0;
    re = 1'b0;
    wa = cur_q[GB+IW-1:GB];
    ra = cur_q[GB+IW-1:GB];
    wd = '0;
    case (cmd_i.op)
      ffha_pkg::OP_CLEAR: begin
        we = 1'b1;
        wa = clr_q;
        if (clr_q == '0 && !tiny) wd = '{used: 1'b1, taken: 1'b0, size: room};
      end
      ffha_pkg::OP_FIRST: begin
        re = 1'b1;
        ra = '0;
      end
      ffha_pkg::OP_ADVANCE: begin
        re = 1'b1;
        ra = nxt[GB+IW-1:GB];
      end
      ffha_pkg::OP_FMATCH: begin
        re = stat_o.adv_ok;
        ra = nxt[GB+IW-1:GB];
      end
      ffha_pkg::OP_SPLIT: begin
        we = 1'b1;
        wa = split_n[GB+IW-1:GB];
        wd = '{used: 1'b1, taken: 1'b0, size: e.size - al_q - Hdr};
      end
      ffha_pkg::OP_GRANT_FULL: begin
        we = 1'b1;
        wd = '{used: 1'b1, taken: 1'b1, size: e.size};
      end
      ffha_pkg::OP_GRANT_AL: begin
        we = 1'b1;
        wd = '{used: 1'b1, taken: 1'b1, size: al_q};
      end
      ffha_pkg::OP_NEXT_EVAL: begin
        we = nmerge;
        wa = blk_n[GB+IW-1:GB];
      end
      ffha_pkg::OP_PREV_MERGE: begin
        we = 1'b1;
        wa = prev_q[GB+IW-1:GB];
        wd = '{used: 1'b1, taken: 1'b0, size: prev_ent_q.size + Hdr + news_q};
      end
      ffha_pkg::OP_SELF_FREE: begin
        we = 1'b1;
        wd = '{used: 1'b1, taken: 1'b0, size: news_q};
      end
      ffha_pkg::OP_SELF_CLEAR: we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) rdata_q <= mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_q      <= HMax;
      free_q      <= HMax - Hdr;
      clr_q       <= '0;
      have_prev_q <= 1'b0;
      nrd_q       <= 1'b0;
      kind_q      <= 1'b0;
    end else if (cfg_we_i) begin
      heap_q <= cfg_wdata_i;
      free_q <= (lenw > Hdr) ? (lenw - Hdr) : '0;
      clr_q  <= '0;
    end else begin
      case (cmd_i.op)
        ffha_pkg::OP_CLEAR:      clr_q <= clr_q + 1'b1;
        ffha_pkg::OP_LOAD: begin
          kind_q      <= kind_i;
          have_prev_q <= 1'b0;
        end
        ffha_pkg::OP_ADVANCE:    have_prev_q <= 1'b1;
        ffha_pkg::OP_FMATCH:     nrd_q <= stat_o.adv_ok;
        ffha_pkg::OP_SPLIT:      free_q <= free_q - al_q - Hdr;
        ffha_pkg::OP_GRANT_FULL: free_q <= free_q - e.size;
        ffha_pkg::OP_NEXT_EVAL:  free_q <= free_q + blk_q.size + (nmerge ? Hdr : '0);
        ffha_pkg::OP_PREV_MERGE: free_q <= free_q + Hdr;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ffha_pkg::OP_LOAD: begin
        req_q     <= request_bytes_i;
        ptr_q     <= payload_offset_i;
        cur_q     <= '0;
        granted_q <= '0;
      end
      default: ;
    endcase
    if (cmd_i.op == ffha_pkg::OP_LOAD) al_q <= '0;
    if (cmd_i.op == ffha_pkg::OP_FIRST) al_q <= SW'(al_raw);
    if (cmd_i.op == ffha_pkg::OP_ADVANCE) begin
      prev_q     <= cur_q;
      prev_ent_q <= e;
      cur_q      <= nxt[AW-1:0];
    end
    if (cmd_i.op == ffha_pkg::OP_FMATCH) blk_q <= e;
    if (cmd_i.op == ffha_pkg::OP_GRANT_FULL || cmd_i.op == ffha_pkg::OP_GRANT_AL) begin
      granted_q <= ffha_pkg::PtrW'(cur_q + Hdr);
    end
    if (cmd_i.op == ffha_pkg::OP_NEXT_EVAL) begin
      news_q <= blk_q.size + (nmerge ? (Hdr + e.size) : '0);
    end
  end

  assign granted_o = granted_q;
  assign free_o    = free_q;

endmodule

`default_nettype wire

/* src/first_fit_heap_allocator.sv */
// Top level of the first-fit heap allocator with coalescing.
// Depends on ffha_pkg, ffha_controller and ffha_datapath.
//
//   Port group            Direction  Handshake
//   request item          in         start taken when busy is low
//   result item           out        done_o high for one cycle, no back-pressure
//   heap_bytes register   in         cfg_we_i, written at the edge, no wait
//
// An item rejected at the check ends there. An allocation walks the blocks, then grants
// the first that fits, splitting it when it is large enough. A free walks up to and
// including the match, folds in a free next block, and merges into a free previous block;
// a double free or a miss ends after the walk.
// After reset and each heap_bytes write, busy stays high while the table is cleared.
// The walk reads one block a cycle, and the receiver cannot stall results.
`default_nettype none

module first_fit_heap_allocator (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [ffha_pkg::SizeW-1:0]  cfg_wdata_i,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        kind_i,
  input  wire logic [ffha_pkg::ReqW-1:0]   request_bytes_i,
  input  wire logic [ffha_pkg::PtrW-1:0]   payload_offset_i,
  output logic                             done_o,
  output logic [2:0]                       status_o,
  output logic [ffha_pkg::PtrW-1:0]        granted_offset_o,
  output logic [ffha_pkg::SizeW-1:0]       free_total_o
);

  ffha_pkg::cmd_t  cmd;
  ffha_pkg::stat_t stat;

  // The controller decides the step; the datapath owns the block table.
  ffha_controller u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_we_i (cfg_we_i),
    .start    (start),
    .busy     (busy),
    .cmd_o    (cmd),
    .stat_i   (stat),
    .done_o   (done_o),
    .status_o (status_o)
  );

  ffha_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .kind_i           (kind_i),
    .request_bytes_i  (request_bytes_i),
    .payload_offset_i (payload_offset_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .granted_o        (granted_offset_o),
    .free_o           (free_total_o)
  );

endmodule

`default_nettype wire

/* src/ffha_checker.sv */
// Port-level checks of the first-fit heap allocator, bound to the top level.
// Depends on first_fit_heap_allocator_defines.svh and ffha_pkg.
`default_nettype none
`include "first_fit_heap_allocator_defines.svh"

module ffha_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        done_o,
  input wire logic [2:0]                  status_o,
  input wire logic [ffha_pkg::PtrW-1:0]   granted_offset_o,
  input wire logic [ffha_pkg::SizeW-1:0]  free_total_o
);

  `FFHA_CHECK(a_accept_busy, start && !busy |=> busy, "accepted item did not raise busy")
  `FFHA_CHECK(a_done_idle, done_o |-> !busy, "result shown while still busy")
  `FFHA_CHECK(a_fail_no_grant, done_o && status_o != 3'(ffha_pkg::ST_OK) |-> granted_offset_o == '0, "failed item reports an offset")
  `FFHA_CHECK(a_free_bound, done_o |-> free_total_o <= ffha_pkg::SizeW'(ffha_pkg::HeapMaxBytes - ffha_pkg::HeaderBytes), "free total beyond heap")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .done_o           (done_o),
  .status_o         (status_o),
  .granted_offset_o (granted_offset_o),
  .free_total_o     (free_total_o)
);

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for the first-fit heap allocator with coalescing.
// Depends on ffha_pkg and the first_fit_heap_allocator RTL; it needs no other files.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ffha_pkg::*;

  localparam int unsigned QuietLimit = 20000;

  // How a queued item is turned into port values when it is driven.
  typedef enum int {
    GEN_ALLOC,      // allocate request_bytes as given
    GEN_FREE_LIVE,  // release a block that is currently allocated
    GEN_FREE_ANY,   // release any existing block, which can be a double free
    GEN_FREE_RAW,   // release the raw payload_offset as given
    GEN_HEAP_WRITE  // write the heap_bytes register
  } gen_e;

  typedef struct {
    gen_e             gen;
    logic [ReqW-1:0]  req;
    logic [PtrW-1:0]  ptr;
    logic [SizeW-1:0] heap;
  } pending_t;

  typedef struct {
    status_e          status;
    logic [PtrW-1:0]  granted;
    logic [SizeW-1:0] free_total;
  } outcome_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [SizeW-1:0] cfg_wdata_i = '0;
  logic             start = 1'b0;
  logic             busy;
  logic             kind_i = 1'b0;
  logic [ReqW-1:0]  request_bytes_i = '0;
  logic [PtrW-1:0]  payload_offset_i = '0;
  logic             done_o;
  logic [2:0]       status_o;
  logic [PtrW-1:0]  granted_offset_o;
  logic [SizeW-1:0] free_total_o;

  first_fit_heap_allocator u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .start, .busy, .kind_i,
    .request_bytes_i, .payload_offset_i, .done_o, .status_o,
    .granted_offset_o, .free_total_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow heap, indexed by the byte offset of a block header.
  logic [SizeW-1:0] heap_setting;
  bit               hdr_mark [HeapMaxBytes];
  int unsigned      blk_size [HeapMaxBytes];
  bit               blk_taken[HeapMaxBytes];
  int unsigned      free_sum;

  pending_t pending_q[$];
  outcome_t outcome_q[$];
  int       errors = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic int unsigned managed_len();
    return (heap_setting > HeapMaxBytes) ? HeapMaxBytes : heap_setting;
  endfunction

  function automatic bit header_at(int unsigned s);
    return s < managed_len() && hdr_mark[s];
  endfunction

  function automatic void rebuild_heap(logic [SizeW-1:0] value);
    int unsigned len;
    heap_setting = value;
    len = managed_len();
    for (int i = 0; i < HeapMaxBytes; i++) begin
      hdr_mark[i] = 0;
      blk_size[i] = 0;
      blk_taken[i] = 0;
    end
    free_sum = 0;
    if (len > HeaderBytes) begin
      hdr_mark[0] = 1;
      blk_size[0] = len - HeaderBytes;
      free_sum = blk_size[0];
    end
  endfunction

  function automatic void sum_free_payload();
    int unsigned s = 0;
    free_sum = 0;
    while (header_at(s)) begin
      if (!blk_taken[s]) free_sum += blk_size[s];
      s = s + HeaderBytes + blk_size[s];
    end
  endfunction

  function automatic outcome_t first_fit_alloc(int unsigned req);
    outcome_t    o;
    int unsigned len, al, s, sz, n;
    o.status = ST_NOMEM;
    o.granted = '0;
    len = managed_len();
    s = 0;
    if (req == 0) begin
      o.status = ST_ZERO;
      return o;
    end
    if (len <= HeaderBytes || req > len - HeaderBytes) return o;
    al = ((req + AlignBytes - 1) / AlignBytes) * AlignBytes;
    while (header_at(s)) begin
      sz = blk_size[s];
      if (!blk_taken[s] && sz >= al) begin
        if (sz > al + HeaderBytes) begin
          n = s + HeaderBytes + al;
          if (n + HeaderBytes <= len) begin
            hdr_mark[n] = 1;
            blk_size[n] = sz - al - HeaderBytes;
            blk_taken[n] = 0;
            blk_size[s] = al;
          end
        end
        blk_taken[s] = 1;
        o.granted = PtrW'(s + HeaderBytes);
        o.status = ST_OK;
        return o;
      end
      s = s + HeaderBytes + blk_size[s];
    end
    return o;
  endfunction

  function automatic status_e release_block(int unsigned ptr);
    int unsigned s = 0, prev = 0, n;
    bit          has_prev = 0;
    if (ptr == 0 || ptr >= managed_len()) return ST_BADPTR;
    while (header_at(s)) begin
      if (s + HeaderBytes == ptr) begin
        if (!blk_taken[s]) return ST_DFREE;
        blk_taken[s] = 0;
        n = s + HeaderBytes + blk_size[s];
        if (header_at(n) && !blk_taken[n]) begin
          blk_size[s] += HeaderBytes + blk_size[n];
          hdr_mark[n] = 0;
        end
        if (has_prev && !blk_taken[prev]) begin
          blk_size[prev] += HeaderBytes + blk_size[s];
          hdr_mark[s] = 0;
        end
        return ST_OK;
      end
      prev = s;
      has_prev = 1;
      s = s + HeaderBytes + blk_size[s];
    end
    // An in-range offset that is no payload changes nothing.
    return ST_OK;
  endfunction

  function automatic outcome_t predict_item(logic k, logic [ReqW-1:0] req,
                                            logic [PtrW-1:0] ptr);
    outcome_t o;
    if (!k) begin
      o = first_fit_alloc(req);
    end else begin
      o.status = release_block(ptr);
      o.granted = '0;
    end
    sum_free_payload();
    o.free_total = SizeW'(free_sum);
    return o;
  endfunction

  // Picks the payload offset of an existing block; falls back to the raw value.
  function automatic logic [PtrW-1:0] pick_block(bit only_taken, logic [PtrW-1:0] raw);
    int unsigned s = 0;
    int unsigned found[$];
    while (header_at(s)) begin
      if (!only_taken || blk_taken[s]) found.push_back(s + HeaderBytes);
      s = s + HeaderBytes + blk_size[s];
    end
    if (found.size() == 0) return raw;
    return PtrW'(found[$urandom_range(found.size() - 1)]);
  endfunction

  task automatic add_item(gen_e g, int unsigned req, int unsigned ptr);
    pending_t p;
    p.gen = g;
    p.req = ReqW'(req);
    p.ptr = PtrW'(ptr);
    p.heap = '0;
    pending_q.push_back(p);
  endtask

  task automatic add_heap_write(int unsigned value);
    pending_t p;
    p.gen = GEN_HEAP_WRITE;
    p.req = '0;
    p.ptr = '0;
    p.heap = SizeW'(value);
    pending_q.push_back(p);
  endtask

  function automatic int unsigned random_request();
    int unsigned r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 120);
    if (r < 90) return $urandom_range(1, 1024);
    if (r < 96) return $urandom_range(0, 4200);
    return $urandom_range(0, 65535);
  endfunction

  // Stimulus: a directed part, then phases of random items on different heap sizes.
  initial begin
    int unsigned r, phase_len, heap;
    add_item(GEN_ALLOC, 0, 0);
    add_item(GEN_ALLOC, 65535, 0);
    add_item(GEN_ALLOC, 4081, 0);
    add_item(GEN_ALLOC, 1, 0);
    add_item(GEN_ALLOC, 8, 0);
    add_item(GEN_ALLOC, 9, 0);
    add_item(GEN_ALLOC, 24, 0);
    add_item(GEN_FREE_RAW, 0, 0);
    add_item(GEN_FREE_RAW, 0, 4095);
    add_item(GEN_FREE_RAW, 0, 20);
    add_item(GEN_FREE_RAW, 0, 48);
    add_item(GEN_FREE_RAW, 0, 48);
    add_item(GEN_FREE_RAW, 0, 16);
    add_item(GEN_FREE_RAW, 0, 32);
    add_item(GEN_ALLOC, 4000, 0);
    add_item(GEN_ALLOC, 200, 0);
    add_heap_write(8);
    add_item(GEN_ALLOC, 1, 0);
    add_item(GEN_FREE_RAW, 0, 4);
    add_heap_write(8191);
    add_item(GEN_ALLOC, 4080, 0);
    add_item(GEN_FREE_RAW, 0, 16);
    add_heap_write(32);
    add_item(GEN_ALLOC, 16, 0);
    add_item(GEN_ALLOC, 17, 0);
    add_item(GEN_ALLOC, 8, 0);
    add_heap_write(0);
    add_item(GEN_ALLOC, 1, 0);
    for (int ph = 0; ph < 12; ph++) begin
      r = $urandom_range(9);
      if (r < 3) heap = 4096;
      else if (r < 4) heap = $urandom_range(4097, 8191);
      else if (r < 5) heap = $urandom_range(0, 40);
      else heap = $urandom_range(32, 4096);
      add_heap_write(heap);
      phase_len = $urandom_range(120, 190);
      for (int i = 0; i < phase_len; i++) begin
        r = $urandom_range(99);
        if (r < 55) add_item(GEN_ALLOC, random_request(), $urandom_range(0, 4095));
        else if (r < 85) add_item(GEN_FREE_LIVE, $urandom_range(0, 65535), $urandom_range(0, 4095));
        else if (r < 90) add_item(GEN_FREE_ANY, $urandom_range(0, 65535), $urandom_range(0, 4095));
        else add_item(GEN_FREE_RAW, $urandom_range(0, 65535), $urandom_range(0, 4095));
      end
    end
    add_heap_write(4096);
    add_item(GEN_ALLOC, 4080, 0);
  end

  // Driver: bursts of items with random gaps; register writes only when idle.
  int unsigned burst_left = 1, gap_left = 0, settle = 0, quiet_cycles = 0;

  always @(posedge clk_i) begin
    logic     next_start, next_we;
    pending_t p;
    next_start = start;
    next_we = 1'b0;
    if (rst_ni) begin
      if (start && !busy) begin
        outcome_q.push_back(predict_item(kind_i, request_bytes_i, payload_offset_i));
        next_start = 1'b0;
      end
      quiet_cycles = done_o ? 0 : quiet_cycles + 1;
      if (settle > 0) settle--;
      if (!next_start && settle == 0 && pending_q.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q[0].gen == GEN_HEAP_WRITE) begin
          // Write only once every result is in and the block has gone quiet.
          if (outcome_q.size() == 0 && !busy && quiet_cycles >= 8) begin
            p = pending_q.pop_front();
            next_we = 1'b1;
            cfg_wdata_i <= p.heap;
            rebuild_heap(p.heap);
            settle = 3;
          end
        end else begin
          p = pending_q.pop_front();
          kind_i <= (p.gen != GEN_ALLOC);
          request_bytes_i <= p.req;
          case (p.gen)
            GEN_FREE_LIVE: payload_offset_i <= pick_block(1, p.ptr);
            GEN_FREE_ANY:  payload_offset_i <= pick_block(0, p.ptr);
            default:       payload_offset_i <= p.ptr;
          endcase
          next_start = 1'b1;
          if (--burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 70);
          end
        end
      end
    end
    start <= next_start;
    cfg_we_i <= next_we;
  end

  // Monitor: every strobed result is checked against the oldest prediction.
  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && done_o) begin
      if (outcome_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d", status_o));
      end else begin
        e = outcome_q.pop_front();
        if (status_o !== e.status)
          report_mismatch($sformatf("status %0d, predicted %0d", status_o, e.status));
        if (granted_offset_o !== e.granted)
          report_mismatch($sformatf("granted_offset %0d, predicted %0d",
                                    granted_offset_o, e.granted));
        if (free_total_o !== e.free_total)
          report_mismatch($sformatf("free_total %0d, predicted %0d",
                                    free_total_o, e.free_total));
      end
    end
  end

  // Watchdog on cycles in which neither an item nor a result is accepted.
  int unsigned idle_count = 0;
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_count = 0;
    else idle_count++;
    if (idle_count >= QuietLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    rebuild_heap(SizeW'(HeapMaxBytes));
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (5) @(posedge clk_i);
    wait (pending_q.size() == 0 && !start && outcome_q.size() == 0);
    repeat (1200) @(posedge clk_i);
    if (errors == 0 && outcome_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      if (outcome_q.size() != 0)
        report_mismatch($sformatf("%0d predicted results never arrived", outcome_q.size()));
      $display("testbench failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
